// File: src/sps_pkg.sv
// Shared types and constants for the segment point sampler.
package sps_pkg;

   localparam int COORD_BITS_DEF  = 12;
   localparam int MAX_RESULTS_DEF = 64;
   localparam int SPACING_BITS    = 12;
   localparam int FRAC_BITS       = 8;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [SPACING_BITS-1:0] SPACING_RESET = 12'd16;

   // register index of point_spacing
   localparam logic REG_POINT_SPACING = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SUM,
      ST_SQRT,
      ST_CHK,
      ST_CMP,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_DONE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      MUL_ADX_SQ,
      MUL_ADY_SQ,
      MUL_NS_SQ,
      MUL_ADX_NS,
      MUL_ADY_NS
   } mul_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        rsp_valid;
      mul_sel_type mul_sel;
      logic        step_div;
   } ctrl_type;

endpackage

// File: src/sps_mult.sv
// Shared registered multiplier of the segment point sampler.
module sps_mult #(
   parameter int WIDTH = 18
) (
   input  logic               clock,
   input  logic [WIDTH-1:0]   op_a,
   input  logic [WIDTH-1:0]   op_b,
   output logic [2*WIDTH-1:0] prod_ff
);

   logic [2*WIDTH-1:0] prod_in;

   assign prod_in = (2*WIDTH)'(op_a) * (2*WIDTH)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: src/sps_sub_unit.sv
// Shared compare and subtract unit for root and quotient digit steps.
module sps_sub_unit #(
   parameter int WIDTH = 24
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic             ge,
   output logic [WIDTH-1:0] diff
);

   logic [WIDTH:0] wide_diff;

   // borrow out of the extended subtract gives the compare
   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge        = ~wide_diff[WIDTH];
   assign diff      = wide_diff[WIDTH-1:0];

endmodule

// File: src/segment_point_sampler_unit.sv
// Top level of the segment point sampler: sequencer, datapath and register port.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  req     | in        | req_valid / req_ready  | x_start, y_start, x_end, y_end
//  rsp     | out       | rsp_valid / rsp_ready  | point_x, point_y, last, empty_segment, clipped
//  csr     | in        | psel, penable, pready  | paddr, pwdata, prdata (point_spacing)
//
// One segment at a time; req_ready is high only while idle. All-zero segment: one
// result, the empty marker. Otherwise squaring, then the square root (one root bit
// per cycle on the shared subtractor), then per sample two divisions of COORD_BITS+1
// quotient bits each; a sample at the start point and the end point take no
// division, and any rsp stall adds to the total.
// Reset is synchronous and clears the sequencer and point_spacing (to 16).
// A stalled result holds in the output registers until taken.
module segment_point_sampler_unit
   import sps_pkg::*;
#(
   parameter int MAX_RESULTS = MAX_RESULTS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // segment in
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_BITS-1:0]    req_x_start,
   input  logic [COORD_BITS-1:0]    req_y_start,
   input  logic [COORD_BITS-1:0]    req_x_end,
   input  logic [COORD_BITS-1:0]    req_y_end,
   // points out
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_point_x,
   output logic [COORD_BITS-1:0]    rsp_point_y,
   output logic                     rsp_last,
   output logic                     rsp_empty_segment,
   output logic                     rsp_clipped,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // sample counter and running n*spacing
   localparam int CNT_W  = $clog2(MAX_RESULTS);
   localparam int NS_W   = CNT_W + SPACING_BITS;
   // multiplier operand and product
   localparam int MW     = (COORD_BITS > NS_W) ? COORD_BITS : NS_W;
   localparam int PW     = 2 * MW;
   // squared length, fixed point length, radicand
   localparam int L2_W   = 2 * COORD_BITS + 1;
   localparam int RW     = COORD_BITS + FRAC_BITS + 1;
   localparam int VW     = 2 * RW;
   // shared subtractor width, covers root and division remainders
   localparam int W      = RW + 3;
   // dividend and quotient
   localparam int NUM_W  = COORD_BITS + NS_W + FRAC_BITS;
   localparam int QW     = COORD_BITS + 1;
   localparam int BIGW   = (NUM_W > W) ? NUM_W : W;
   localparam int SC_W   = $clog2(RW);
   localparam int CMPW   = (PW > L2_W) ? PW : L2_W;

   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_RESULTS - 1);
   localparam logic [SC_W-1:0]  SQRT_LAST = SC_W'(RW - 1);
   localparam logic [SC_W-1:0]  DIV_LAST  = SC_W'(QW - 1);

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [SPACING_BITS-1:0] spacing_ff, spacing_in;

   logic [COORD_BITS-1:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic [COORD_BITS-1:0] xs_in, ys_in, xe_in, ye_in;
   logic [L2_W-1:0]       l2_ff, l2_in;
   logic [VW-1:0]         v_ff, v_in;
   logic [W-1:0]          r_ff, r_in;
   logic [RW-1:0]         q_ff, q_in;      // root, then segment length
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [QW-1:0]         quot_ff, quot_in;
   logic [SC_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [NS_W-1:0]       ns_ff, ns_in;
   logic                  sel_y_ff, sel_y_in;
   logic                  fin_ff, fin_in;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic                  last_ff, last_in, empty_ff, empty_in, clip_ff, clip_in;

   logic                  req_take, rsp_take, all_zero;
   logic                  xneg, yneg;
   logic [COORD_BITS-1:0] adx, ady, off, x_off, y_off;
   logic [MW-1:0]         mul_a, mul_b;
   logic [PW-1:0]         prod_ff;
   logic [W-1:0]          sub_a, sub_b, sub_diff;
   logic                  sub_ge;
   logic [L2_W-1:0]       l2_sum;
   logic [NUM_W-1:0]      num_load;
   logic [BIGW-1:0]       rem_init;
   logic                  over, at_limit, no_div, step_done;
   logic                  csr_write;

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_POINT_SPACING) ? CSR_DATA_BITS'(spacing_ff) : '0;

   always_comb begin
      spacing_in = spacing_ff;
      if (csr_write && (paddr[2] == REG_POINT_SPACING)) begin
         spacing_in = pwdata[SPACING_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- shared units
   sps_mult #(
      .WIDTH (MW)
   ) u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   sps_sub_unit #(
      .WIDTH (W)
   ) u_sub (
      .op_a (sub_a),
      .op_b (sub_b),
      .ge   (sub_ge),
      .diff (sub_diff)
   );

   // ---------------------------------------------------------------- conditions
   assign req_take = req_valid && ctrl.req_ready;
   assign rsp_take = ctrl.rsp_valid && rsp_ready;
   assign all_zero = (req_x_start == '0) && (req_y_start == '0) &&
                     (req_x_end == '0) && (req_y_end == '0);

   assign xneg = xe_ff < xs_ff;
   assign yneg = ye_ff < ys_ff;
   assign adx  = xneg ? (xs_ff - xe_ff) : (xe_ff - xs_ff);
   assign ady  = yneg ? (ys_ff - ye_ff) : (ye_ff - ys_ff);

   assign l2_sum    = l2_ff + L2_W'(prod_ff);
   assign over      = CMPW'(prod_ff) > CMPW'(l2_ff);
   assign at_limit  = n_ff == LAST_SLOT;
   assign no_div    = (ns_ff == '0) || (q_ff == '0);
   assign step_done = step_ff == '0;

   // dividend = |d| * ns * 256; quotient is known to fit in COORD_BITS+1 bits,
   // so the top part starts as the remainder
   assign num_load = {prod_ff[COORD_BITS+NS_W-1:0], FRAC_BITS'(0)};
   assign rem_init = BIGW'(num_load >> QW);

   assign off   = quot_ff[COORD_BITS-1:0];
   assign x_off = xneg ? (xs_ff - off) : (xs_ff + off);
   assign y_off = yneg ? (ys_ff - off) : (ys_ff + off);

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_ADX_SQ: begin
            mul_a = MW'(adx);
            mul_b = MW'(adx);
         end
         MUL_ADY_SQ: begin
            mul_a = MW'(ady);
            mul_b = MW'(ady);
         end
         MUL_NS_SQ: begin
            mul_a = MW'(ns_ff);
            mul_b = MW'(ns_ff);
         end
         MUL_ADX_NS: begin
            mul_a = MW'(adx);
            mul_b = MW'(ns_ff);
         end
         MUL_ADY_NS: begin
            mul_a = MW'(ady);
            mul_b = MW'(ns_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // root step brings in two radicand bits; division step brings in one dividend bit
   always_comb begin
      if (ctrl.step_div) begin
         sub_a = {r_ff[W-2:0], num_ff[COORD_BITS]};
         sub_b = W'(q_ff);
      end else begin
         sub_a = {r_ff[W-3:0], v_ff[VW-1 -: 2]};
         sub_b = W'({q_ff, 2'b01});
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = all_zero ? ST_EMIT : ST_SQ_X;
            end
         end
         ST_SQ_X:     state_in = ST_SQ_Y;
         ST_SQ_Y:     state_in = ST_SUM;
         ST_SUM:      state_in = ST_SQRT;
         ST_SQRT: begin
            if (step_done) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK:      state_in = ST_CMP;
         ST_CMP: begin
            if (over || at_limit || no_div) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (step_done) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: state_in = sel_y_ff ? ST_EMIT : ST_DIV_LOAD;
         ST_EMIT: begin
            if (rsp_take) begin
               state_in = fin_ff ? ST_IDLE : ST_CHK;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- sequencer outputs
   always_comb begin
      ctrl           = '0;
      ctrl.mul_sel   = MUL_NS_SQ;
      unique case (state_ff)
         ST_IDLE:     ctrl.req_ready = 1'b1;
         ST_SQ_X:     ctrl.mul_sel   = MUL_ADX_SQ;
         ST_SQ_Y:     ctrl.mul_sel   = MUL_ADY_SQ;
         ST_CMP:      ctrl.mul_sel   = MUL_ADX_NS;
         ST_DIV_DONE: ctrl.mul_sel   = MUL_ADY_NS;
         ST_DIV_RUN:  ctrl.step_div  = 1'b1;
         ST_EMIT:     ctrl.rsp_valid = 1'b1;
         default:     ctrl.mul_sel   = MUL_NS_SQ;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      xs_in    = xs_ff;
      ys_in    = ys_ff;
      xe_in    = xe_ff;
      ye_in    = ye_ff;
      l2_in    = l2_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      ns_in    = ns_ff;
      sel_y_in = sel_y_ff;
      fin_in   = fin_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      clip_in  = clip_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               xs_in    = req_x_start;
               ys_in    = req_y_start;
               xe_in    = req_x_end;
               ye_in    = req_y_end;
               // empty marker; goes straight out for an all-zero segment
               px_in    = '0;
               py_in    = '0;
               last_in  = 1'b1;
               empty_in = 1'b1;
               clip_in  = 1'b0;
               fin_in   = 1'b1;
            end
         end
         ST_SQ_X: begin
         end
         ST_SQ_Y: begin
            l2_in = L2_W'(prod_ff);
         end
         ST_SUM: begin
            l2_in   = l2_sum;
            v_in    = VW'(l2_sum) << (2 * FRAC_BITS);
            r_in    = '0;
            q_in    = '0;
            step_in = SQRT_LAST;
         end
         ST_SQRT: begin
            r_in    = sub_ge ? sub_diff : sub_a;
            q_in    = {q_ff[RW-2:0], sub_ge};
            v_in    = v_ff << 2;
            step_in = step_ff - 1'b1;
            n_in    = '0;
            ns_in   = '0;
         end
         ST_CHK: begin
            sel_y_in = 1'b0;
         end
         ST_CMP: begin
            empty_in = 1'b0;
            if (over || at_limit) begin
               // end point; clipped when one more sample would still fit
               px_in   = xe_ff;
               py_in   = ye_ff;
               last_in = 1'b1;
               clip_in = !over;
               fin_in  = 1'b1;
            end else if (no_div) begin
               px_in   = xs_ff;
               py_in   = ys_ff;
               last_in = 1'b0;
               clip_in = 1'b0;
               fin_in  = 1'b0;
            end
         end
         ST_DIV_LOAD: begin
            num_in  = num_load;
            r_in    = rem_init[W-1:0];
            quot_in = '0;
            step_in = DIV_LAST;
         end
         ST_DIV_RUN: begin
            r_in    = sub_ge ? sub_diff : sub_a;
            quot_in = {quot_ff[QW-2:0], sub_ge};
            num_in  = num_ff << 1;
            step_in = step_ff - 1'b1;
         end
         ST_DIV_DONE: begin
            if (sel_y_ff) begin
               py_in   = y_off;
               last_in = 1'b0;
               clip_in = 1'b0;
               fin_in  = 1'b0;
            end else begin
               px_in    = x_off;
               sel_y_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_take && !fin_ff) begin
               n_in  = n_ff + 1'b1;
               ns_in = ns_ff + NS_W'(spacing_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         spacing_ff <= SPACING_RESET;
      end else begin
         state_ff   <= state_in;
         spacing_ff <= spacing_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff    <= xs_in;
      ys_ff    <= ys_in;
      xe_ff    <= xe_in;
      ye_ff    <= ye_in;
      l2_ff    <= l2_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      n_ff     <= n_in;
      ns_ff    <= ns_in;
      sel_y_ff <= sel_y_in;
      fin_ff   <= fin_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
      clip_ff  <= clip_in;
   end

   // ---------------------------------------------------------------- outputs
   assign req_ready         = ctrl.req_ready;
   assign rsp_valid         = ctrl.rsp_valid;
   assign rsp_point_x       = px_ff;
   assign rsp_point_y       = py_ff;
   assign rsp_last          = last_ff;
   assign rsp_empty_segment = empty_ff;
   assign rsp_clipped       = clip_ff;

`ifndef SYNTHESIS
   a_no_accept_while_pending : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("segment taken while a point is pending");

   a_empty_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_segment |-> rsp_last)
      else $error("empty marker not flagged last");

   a_clip_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_last && !rsp_empty_segment)
      else $error("clip flag on a non-final point");

   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not idle after final point");

   a_sample_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> n_ff != LAST_SLOT)
      else $error("sample emitted beyond the result limit");
`endif

endmodule
